@@ hdl/mips_ex_pkg.sv @@
// types and constants shared by the mips32 integer execute unit
// no dependencies
package mips_ex_pkg;

   typedef enum logic [5:0] {
      OP_SLL = 6'd0, OP_SRL = 6'd1, OP_SRA = 6'd2, OP_SLLV = 6'd3, OP_SRLV = 6'd4,
      OP_MOVN = 6'd5, OP_MOVZ = 6'd6, OP_SRAV = 6'd7, OP_JR = 6'd8, OP_JALR = 6'd9,
      OP_SYSCALL = 6'd10, OP_TNE = 6'd11, OP_MFHI = 6'd12, OP_MTHI = 6'd13,
      OP_MFLO = 6'd14, OP_MTLO = 6'd15, OP_MADD = 6'd16, OP_MULT = 6'd17,
      OP_DIV = 6'd18, OP_MUL = 6'd19, OP_MULTU = 6'd20, OP_ADDU = 6'd21,
      OP_SUBU = 6'd22, OP_AND = 6'd23, OP_OR = 6'd24, OP_XOR = 6'd25, OP_NOR = 6'd26,
      OP_SLT = 6'd27, OP_SLTU = 6'd28, OP_BLTZ = 6'd29, OP_BGEZ = 6'd30, OP_J = 6'd31,
      OP_JAL = 6'd32, OP_BEQ = 6'd33, OP_BNE = 6'd34, OP_BLEZ = 6'd35,
      OP_BNEZL = 6'd36, OP_BGTZ = 6'd37, OP_ADDIU = 6'd38, OP_SLTI = 6'd39,
      OP_SLTIU = 6'd40, OP_ANDI = 6'd41, OP_ORI = 6'd42, OP_XORI = 6'd43,
      OP_LUI = 6'd44, OP_CACHE = 6'd45
   } op_type;

   typedef enum logic [1:0] {
      TRAP_NONE = 2'd0, TRAP_SYSCALL = 2'd1, TRAP_TNE = 2'd2
   } trap_type;

   localparam logic [31:0] PC_REGION_MASK = 32'hf000_0000;
   localparam logic [31:0] SET_TRUE = 32'h0000_0001;
   localparam logic [4:0]  LINK_REG = 5'd31;

   // request to the shared multiply/divide unit
   typedef struct packed {
      logic        start;
      logic        is_div;
      logic        sgn;
      logic [31:0] a;
      logic [31:0] b;
   } md_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] hi;
      logic [31:0] lo;
   } md_rsp_type;

endpackage

@@ hdl/mips_ex_muldiv.sv @@
// iterative multiply/divide unit, one bit per cycle
// depends on mips_ex_pkg
module mips_ex_muldiv (
   input  logic                    clock,
   input  logic                    reset,
   input  mips_ex_pkg::md_req_type req,
   output mips_ex_pkg::md_rsp_type rsp
);
   import mips_ex_pkg::*;

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        div_ff, div_in;
   logic        nq_ff, nq_in, nr_ff, nr_in;
   logic [31:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;   // mul: product/multiplier, div: remainder/quotient
   logic        done_ff, done_in;
   logic [31:0] ma, mb;
   logic [32:0] sum, diff;
   logic [31:0] q_fin, r_fin;
   logic [63:0] p_fin;

   always_comb begin
      ma = (req.sgn && req.a[31]) ? (32'd0 - req.a) : req.a;
      mb = (req.sgn && req.b[31]) ? (32'd0 - req.b) : req.b;
      sum  = {1'b0, acc_ff[63:32]} + (acc_ff[0] ? {1'b0, b_ff} : 33'd0);
      diff = {acc_ff[62:31]} - {1'b0, b_ff};
      busy_in = busy_ff; cnt_in = cnt_ff; div_in = div_ff; nq_in = nq_ff; nr_in = nr_ff;
      b_in = b_ff; acc_in = acc_ff; done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1; cnt_in = 5'd0; div_in = req.is_div;
         nq_in = req.sgn && (req.a[31] ^ req.b[31]);
         nr_in = req.sgn && req.a[31];
         b_in = mb; acc_in = {32'd0, ma};
      end else if (busy_ff) begin
         if (div_ff) begin
            // restoring step on shifted remainder
            if (!diff[32]) acc_in = {diff[31:0], acc_ff[30:0], 1'b1};
            else acc_in = {acc_ff[62:0], 1'b0};
         end else begin
            acc_in = {sum, acc_ff[31:1]};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   assign q_fin = nq_ff ? (32'd0 - acc_ff[31:0]) : acc_ff[31:0];
   assign r_fin = nr_ff ? (32'd0 - acc_ff[63:32]) : acc_ff[63:32];
   assign p_fin = nq_ff ? (64'd0 - acc_ff) : acc_ff;

   always_comb begin
      rsp.done = done_ff;
      if (div_ff) begin
         rsp.hi = r_fin; rsp.lo = q_fin;
      end else begin
         rsp.hi = p_fin[63:32]; rsp.lo = p_fin[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= 5'd0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      div_ff <= div_in; nq_ff <= nq_in; nr_ff <= nr_in; b_ff <= b_in; acc_ff <= acc_in;
   end

endmodule

@@ hdl/mips32_integer_execute_top.sv @@
// top level of the mips32 integer execute unit
// depends on mips_ex_pkg and mips_ex_muldiv
//
// One instruction is accepted per req transfer. Its source registers are read from the
// register file memory at that transfer edge. After the req transfer, most instructions,
// and div by zero, pass through ST_READ and ST_EXEC to ST_OUT, where rsp_tvalid rises.
// mult, multu, mul and div go through a shared bit-serial multiply/divide unit and wait
// in ST_MD between ST_EXEC and ST_OUT. madd uses the unit too and then passes through
// ST_ADD, which adds the high word of HI:LO. req_tready returns in the cycle after the
// result transfer. The pc reloads from start_address on reset only, and req_tready
// stays low in the first cycle after reset.
module mips32_integer_execute_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind[5:0] src_reg[10:6] tgt_reg[15:11] dst_reg[20:16] shift_amount[25:21]
   // immediate[41:26] jump_field[67:42], zero fill to 72
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // next_pc[31:0] reg_write[32] write_index[37:33] write_value[69:38]
   // trap_kind[71:70]
   output logic [71:0] rsp_tdata
);
   import mips_ex_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001, ST_READ = 6'b000010, ST_EXEC = 6'b000100,
      ST_MD = 6'b001000, ST_ADD = 6'b010000, ST_OUT = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] gpr_mem [32];
   logic [31:0] valid_ff;     // written-since-reset bits; unwritten reads zero
   logic [31:0] a_raw_ff, b_raw_ff;
   logic [71:0] ins_ff;
   logic [31:0] hi_ff, lo_ff, pc_ff, start_ff;
   logic        started_ff;
   logic [71:0] out_ff, out_in;
   logic        madd_c_ff;
   logic        wen;
   logic [4:0]  widx;
   logic [31:0] wval, npc, a, b;
   logic [1:0]  trap;
   logic [31:0] hi_in, lo_in;
   logic        madd_c_in;
   md_req_type  mreq;
   md_rsp_type  mrsp;
   op_type      op;
   logic [4:0]  rs, rt, rd, sa;
   logic [15:0] imm;
   logic [25:0] jf;
   logic [31:0] simm, seq, br, jt;
   logic [32:0] lsum;

   assign op  = op_type'(ins_ff[5:0]);
   assign rs  = ins_ff[10:6];
   assign rt  = ins_ff[15:11];
   assign rd  = ins_ff[20:16];
   assign sa  = ins_ff[25:21];
   assign imm = ins_ff[41:26];
   assign jf  = ins_ff[67:42];
   assign a = (rs != 5'd0 && valid_ff[rs]) ? a_raw_ff : 32'd0;
   assign b = (rt != 5'd0 && valid_ff[rt]) ? b_raw_ff : 32'd0;
   assign simm = {{16{imm[15]}}, imm};
   assign seq = pc_ff + 32'd4;
   assign br = seq + {simm[29:0], 2'b00};
   assign jt = (pc_ff & PC_REGION_MASK) | {4'd0, jf, 2'b00};

   mips_ex_muldiv u_md (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));

   assign req_tready = (state_ff == ST_IDLE) && started_ff;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = out_ff;

   always_comb begin
      mreq.start = (state_ff == ST_EXEC) &&
         (op == OP_MADD || op == OP_MULT || op == OP_MULTU || op == OP_MUL ||
          (op == OP_DIV && b != 32'd0));
      mreq.is_div = (op == OP_DIV);
      mreq.sgn = (op != OP_MULTU);
      mreq.a = a;
      mreq.b = b;
   end

   always_comb begin
      wen = 1'b0; widx = rd; wval = 32'd0; npc = seq; trap = TRAP_NONE;
      hi_in = hi_ff; lo_in = lo_ff; madd_c_in = madd_c_ff;
      lsum = {1'b0, lo_ff} + {1'b0, mrsp.lo};
      unique case (op)
         OP_SLL:  begin wen = 1'b1; wval = b << sa; end
         OP_SRL:  begin wen = 1'b1; wval = b >> sa; end
         OP_SRA:  begin wen = 1'b1; wval = $signed(b) >>> sa; end
         OP_SLLV: begin wen = 1'b1; wval = b << a[4:0]; end
         OP_SRLV: begin wen = 1'b1; wval = b >> a[4:0]; end
         OP_MOVN: begin wen = (b != 32'd0); wval = a; end
         OP_MOVZ: begin wen = (b == 32'd0); wval = a; end
         OP_SRAV: begin wen = 1'b1; wval = $signed(b) >>> a[4:0]; end
         OP_JR:   npc = a;
         OP_JALR: begin npc = a; wen = 1'b1; wval = seq; end
         OP_SYSCALL: begin npc = pc_ff; trap = TRAP_SYSCALL; end
         OP_TNE:  if (a != b) trap = TRAP_TNE;
         OP_MFHI: begin wen = 1'b1; wval = hi_ff; end
         OP_MTHI: hi_in = a;
         OP_MFLO: begin wen = 1'b1; wval = lo_ff; end
         OP_MTLO: lo_in = a;
         OP_MADD: begin
            // low word in ST_MD, high word with carry in ST_ADD
            if (state_ff == ST_MD) begin lo_in = lsum[31:0]; madd_c_in = lsum[32]; end
            else hi_in = hi_ff + mrsp.hi + {31'd0, madd_c_ff};
         end
         OP_MULT, OP_MULTU: begin hi_in = mrsp.hi; lo_in = mrsp.lo; end
         // divide by zero leaves hi and lo alone
         OP_DIV:  if (b != 32'd0) begin hi_in = mrsp.hi; lo_in = mrsp.lo; end
         OP_MUL:  begin wen = 1'b1; wval = mrsp.lo; end
         OP_ADDU: begin wen = 1'b1; wval = a + b; end
         OP_SUBU: begin wen = 1'b1; wval = a - b; end
         OP_AND:  begin wen = 1'b1; wval = a & b; end
         OP_OR:   begin wen = 1'b1; wval = a | b; end
         OP_XOR:  begin wen = 1'b1; wval = a ^ b; end
         OP_NOR:  begin wen = 1'b1; wval = ~(a | b); end
         OP_SLT:  begin wen = 1'b1; wval = ($signed(a) < $signed(b)) ? SET_TRUE : 32'd0; end
         OP_SLTU: begin wen = 1'b1; wval = (a < b) ? SET_TRUE : 32'd0; end
         OP_BLTZ: if (a[31]) npc = br;
         OP_BGEZ: if (!a[31]) npc = br;
         OP_J:    npc = jt;
         OP_JAL:  begin wen = 1'b1; widx = LINK_REG; wval = seq; npc = jt; end
         OP_BEQ:  if (a == b) npc = br;
         OP_BNE:  if (a != b) npc = br;
         OP_BLEZ: if (a[31] || a == 32'd0) npc = br;
         OP_BNEZL: if (a != 32'd0) npc = br;
         OP_BGTZ: if (!a[31] && a != 32'd0) npc = br;
         OP_ADDIU: begin wen = 1'b1; widx = rt; wval = a + simm; end
         OP_SLTI: begin
            wen = 1'b1; widx = rt;
            wval = ($signed(a) < $signed(simm)) ? SET_TRUE : 32'd0;
         end
         OP_SLTIU: begin wen = 1'b1; widx = rt; wval = (a < simm) ? SET_TRUE : 32'd0; end
         OP_ANDI: begin wen = 1'b1; widx = rt; wval = a & {16'd0, imm}; end
         OP_ORI:  begin wen = 1'b1; widx = rt; wval = a | {16'd0, imm}; end
         OP_XORI: begin wen = 1'b1; widx = rt; wval = a ^ {16'd0, imm}; end
         OP_LUI:  begin wen = 1'b1; widx = rt; wval = {imm, 16'd0}; end
         default: ;
      endcase
      if (widx == 5'd0) wen = 1'b0;
      if (!wen) begin widx = 5'd0; wval = 32'd0; end
      out_in = {trap, wval, widx, wen, npc};
   end

   always_comb begin
      state_in = state_ff;
      priority case (1'b1)
         state_ff[0]: if (req_tvalid && req_tready) state_in = ST_READ;
         state_ff[1]: state_in = ST_EXEC;
         state_ff[2]: state_in = mreq.start ? ST_MD : ST_OUT;
         state_ff[3]: if (mrsp.done) state_in = (op == OP_MADD) ? ST_ADD : ST_OUT;
         state_ff[4]: state_in = ST_OUT;
         state_ff[5]: if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // register file memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         a_raw_ff <= gpr_mem[req_tdata[10:6]];
         b_raw_ff <= gpr_mem[req_tdata[15:11]];
      end
      if (state_in == ST_OUT && state_ff != ST_OUT && out_in[32])
         gpr_mem[out_in[37:33]] <= out_in[69:38];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; valid_ff <= 32'd0; hi_ff <= 32'd0; lo_ff <= 32'd0;
         started_ff <= 1'b0; madd_c_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         started_ff <= 1'b1;
         if (!started_ff) pc_ff <= start_ff;
         if (state_in == ST_OUT && state_ff != ST_OUT) begin
            pc_ff <= out_in[31:0];
            if (out_in[32]) valid_ff[out_in[37:33]] <= 1'b1;
         end
         if (state_ff == ST_EXEC && !mreq.start || state_ff == ST_MD && mrsp.done ||
             state_ff == ST_ADD) begin
            hi_ff <= hi_in; lo_ff <= lo_in; madd_c_ff <= madd_c_in;
         end
      end
      if (reset) start_ff <= 32'd0;
      else if (csr_wr_en) start_ff <= csr_wr_data;
      if (req_tvalid && req_tready) ins_ff <= req_tdata;
      if (state_in == ST_OUT && state_ff != ST_OUT) out_ff <= out_in;
   end

   a_no_r0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[32] && rsp_tdata[37:33] == 5'd0))
      else $error("write to register zero reported");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("ready while result pending");
   a_md_done: assert property (@(posedge clock) disable iff (reset)
      mrsp.done |-> state_ff == ST_MD)
      else $error("muldiv finished outside wait state");

endmodule
